### src/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

    localparam int CHAN_W  = 8;
    localparam int INDEX_W = 8;
    localparam int SIZE_W  = 9;
    // three squared 8-bit differences summed
    localparam int DIST_W  = 18;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    // action codes carried in tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_MAP   = 1'b1;

    // one item moving down the cell chain, with the running best match
    typedef struct packed {
        logic                 action;
        logic [INDEX_W-1:0]   entry_index;
        logic [CHAN_W-1:0]    red;
        logic [CHAN_W-1:0]    green;
        logic [CHAN_W-1:0]    blue;
        logic [DIST_W-1:0]    best_dist;
        logic [INDEX_W-1:0]   best_index;
    } npc_item_t;

endpackage

`default_nettype wire

### src/nearest_palette_color.sv
// ----------------------------------------------------------------------------
// nearest_palette_color
// Maps 24-bit pixels to the index of the nearest color of a stored palette.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel. tuser selects the kind: a write item
// stores red/green/blue into palette entry entry_index and gives no result,
// a map item returns on m_axis the index of the nearest searched entry by
// squared euclidean distance, lowest index on a tie.
// The palette is a row of PALETTE_ENTRIES cells, one entry per cell; every
// item moves one cell per cycle unless the chain holds, so a map sees all
// writes accepted before it. Results pass every cell register, then the
// output register; one item is accepted every cycle while the chain runs.
// cfg_we/cfg_wdata set palette_size, the count of entries searched from zero
// (zero acts as one, values above PALETTE_ENTRIES saturate); write it only
// while the chain is empty. Reset empties the chain and sets palette_size to
// 256; palette colors are not cleared and must be written before use.
// When m_axis stalls with a result waiting and another map reaches the end
// of the chain, the whole chain holds and s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [8:0]  cfg_wdata,       // palette_size
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,    // entry_index, red, green, blue
    input  wire  [0:0]  s_axis_tuser,    // action
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata     // palette_index
);
    import npc_pkg::*;

    logic [SIZE_W-1:0]  palette_size_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;

    logic               valid_chain [0:PALETTE_ENTRIES];
    npc_item_t          item_chain  [0:PALETTE_ENTRIES];
    logic               advance;
    logic               last_map;

    assign item_chain[0] = '{action:      s_axis_tuser[0],
                             entry_index: s_axis_tdata[7:0],
                             red:         s_axis_tdata[15:8],
                             green:       s_axis_tdata[23:16],
                             blue:        s_axis_tdata[31:24],
                             best_dist:   '0,
                             best_index:  '0};

    assign valid_chain[0] = s_axis_tvalid && advance;

    genvar gi;
    generate
        for (gi = 0; gi < PALETTE_ENTRIES; gi++)
        begin : g_cell
            npc_cell #(
                .CELL_INDEX (gi)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .enable       (advance),
                .palette_size (palette_size_reg),
                .in_valid     (valid_chain[gi]),
                .in_item      (item_chain[gi]),
                .out_valid    (valid_chain[gi+1]),
                .out_item     (item_chain[gi+1])
            );
        end
    endgenerate

    // only a map result at the end of the chain needs the output register
    assign last_map = valid_chain[PALETTE_ENTRIES]
                   && (item_chain[PALETTE_ENTRIES].action == ACT_MAP);
    assign advance  = !(out_valid_reg && !m_axis_tready && last_map);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_size_reg <= SIZE_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                palette_size_reg <= cfg_wdata;
            end
            if (advance && last_map)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_map)
        begin
            out_index_reg <= item_chain[PALETTE_ENTRIES].best_index;
        end
    end

    assign s_axis_tready = advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_index_reg;

endmodule

`default_nettype wire

### src/npc_cell.sv
// ----------------------------------------------------------------------------
// npc_cell
// One palette entry: stores its color, compares a passing pixel against it
// and hands the item with the updated best match to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       enable,
    input  wire [8:0]                 palette_size,
    input  wire                       in_valid,
    input  wire npc_pkg::npc_item_t   in_item,
    output logic                      out_valid,
    output npc_pkg::npc_item_t        out_item
);
    import npc_pkg::*;

    logic [3*CHAN_W-1:0] color_reg;
    logic                valid_reg;
    npc_item_t           item_reg;
    npc_item_t           item_next;

    logic [CHAN_W-1:0]   diff_r;
    logic [CHAN_W-1:0]   diff_g;
    logic [CHAN_W-1:0]   diff_b;
    logic [2*CHAN_W-1:0] sq_r;
    logic [2*CHAN_W-1:0] sq_g;
    logic [2*CHAN_W-1:0] sq_b;
    logic [DIST_W-1:0]   cand_dist;
    logic                searched;
    logic                take;
    logic                write_hit;

    always_comb
    begin
        diff_r = (color_reg[23:16] > in_item.red) ? color_reg[23:16] - in_item.red
                                                  : in_item.red - color_reg[23:16];
        diff_g = (color_reg[15:8] > in_item.green) ? color_reg[15:8] - in_item.green
                                                   : in_item.green - color_reg[15:8];
        diff_b = (color_reg[7:0] > in_item.blue) ? color_reg[7:0] - in_item.blue
                                                 : in_item.blue - color_reg[7:0];
        sq_r = diff_r * diff_r;
        sq_g = diff_g * diff_g;
        sq_b = diff_b * diff_b;
        cand_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

        // entry zero is always searched and seeds the best match
        searched = (SIZE_W'(CELL_INDEX) < palette_size);
        take     = (CELL_INDEX == 0) || (searched && (cand_dist < in_item.best_dist));

        item_next = in_item;
        if (in_item.action == ACT_MAP && take)
        begin
            item_next.best_dist  = cand_dist;
            item_next.best_index = INDEX_W'(CELL_INDEX);
        end

        write_hit = in_valid && (in_item.action == ACT_WRITE)
                 && (in_item.entry_index == INDEX_W'(CELL_INDEX));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            item_reg <= item_next;
            if (write_hit)
            begin
                color_reg <= {in_item.red, in_item.green, in_item.blue};
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

### verif/npc_result_monitor.sv
// ----------------------------------------------------------------------------
// npc_result_monitor
// Predicts and checks the palette index of every map transfer.
// ----------------------------------------------------------------------------
// Watches the config port and both stream channels. Write transfers update a
// shadow palette, map transfers queue the index of the nearest searched
// entry (squared distance, lowest index on a tie), and every result transfer
// is compared against the oldest queued index.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_result_monitor #(
    parameter int ENTRIES = 256
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       cfg_we,
    input  wire [npc_pkg::SIZE_W-1:0] cfg_wdata,
    input  wire                       s_axis_tvalid,
    input  wire                       s_axis_tready,
    input  wire [31:0]                s_axis_tdata,    // entry_index, red, green, blue
    input  wire [0:0]                 s_axis_tuser,    // action
    input  wire                       m_axis_tvalid,
    input  wire                       m_axis_tready,
    input  wire [7:0]                 m_axis_tdata,    // palette_index
    output int                        mismatches,
    output int                        pending
);
    import npc_pkg::*;

    logic [23:0]        palette_shadow [ENTRIES];
    logic [SIZE_W-1:0]  search_size;
    logic [INDEX_W-1:0] expected_index_q [$];

    function automatic int chan_dist_sq(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
        int d;
        d = int'(a) - int'(b);
        return d * d;
    endfunction

    function automatic logic [INDEX_W-1:0] nearest_index(input logic [CHAN_W-1:0] r,
                                                         input logic [CHAN_W-1:0] g,
                                                         input logic [CHAN_W-1:0] b);
        int          count;
        int          best;
        int          best_dist;
        int          dist_sq;
        logic [23:0] color;
        count = (search_size == 0) ? 1 : ((search_size > ENTRIES) ? ENTRIES : search_size);
        best = 0;
        best_dist = 0;
        for (int e = 0; e < count; e++)
        begin
            color = palette_shadow[e];
            dist_sq = chan_dist_sq(color[23:16], r) + chan_dist_sq(color[15:8], g)
                    + chan_dist_sq(color[7:0], b);
            // strict compare keeps the lowest index on a tie
            if (e == 0 || dist_sq < best_dist)
            begin
                best_dist = dist_sq;
                best = e;
            end
        end
        return best[INDEX_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_size <= SIZE_RESET;
            expected_index_q.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                search_size <= cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == ACT_MAP)
                    expected_index_q.insert(expected_index_q.size(),
                                            nearest_index(s_axis_tdata[15:8],
                                                          s_axis_tdata[23:16],
                                                          s_axis_tdata[31:24]));
                else if (int'(s_axis_tdata[7:0]) < ENTRIES)
                    palette_shadow[s_axis_tdata[7:0]] <=
                        {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_index_q.size() == 0)
                begin
                    $error("palette_index: result transfer with nothing expected, actual %0d",
                           m_axis_tdata);
                    mismatches++;
                end
                else if (m_axis_tdata !== expected_index_q[0])
                begin
                    $error("palette_index mismatch: expected %0d, actual %0d",
                           expected_index_q[0], m_axis_tdata);
                    mismatches++;
                    void'(expected_index_q.pop_front());
                end
                else
                    void'(expected_index_q.pop_front());
            end
            pending = expected_index_q.size();
        end
    end

endmodule

`default_nettype wire

### verif/tb_nearest_palette_color.sv
// ----------------------------------------------------------------------------
// tb_nearest_palette_color
// Stimulus and verdict for the nearest palette color mapper.
// ----------------------------------------------------------------------------
// Directed palette and pixel cases at small sizes, then a full palette fill
// and random write/map traffic over several search sizes, including zero and
// values past the palette depth. The sender idles in bursts, the receiver
// stalls on its own pattern, and npc_result_monitor checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nearest_palette_color;
    import npc_pkg::*;

    localparam int ENTRIES = 256;
    // chain latency plus margin, used before config writes and at the end
    localparam int SETTLE_CYCLES = ENTRIES + 16;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;    // entry_index, red, green, blue
    logic [0:0]        s_axis_tuser = '0;    // action
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;         // palette_index

    int mismatches;
    int pending;
    int burst_left = 0;
    int stall_left = 0;
    int cycle_cnt = 0;

    nearest_palette_color #(
        .PALETTE_ENTRIES(ENTRIES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    npc_result_monitor #(
        .ENTRIES(ENTRIES)
    ) i_result_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: free-running, random, long stalls and alternating, by phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            cycle_cnt <= 0;
            stall_left <= 0;
        end
        else
        begin
            cycle_cnt <= cycle_cnt + 1;
            case (cycle_cnt[9:8])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left <= stall_left - 1;
                        m_axis_tready <= 1'b0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 7) == 0)
                            stall_left <= $urandom_range(1, 15);
                        m_axis_tready <= 1'b1;
                    end
                end
                default: m_axis_tready <= cycle_cnt[0];
            endcase
        end
    end

    // channel value biased toward the extremes and the midpoint to provoke ties
    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h7f;
            3: return 8'h80;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
                             input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {b, g, r, idx};
        // tready is stable mid-cycle, so the transfer happens at the next edge
        @(negedge clk);
        while (!s_axis_tready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_search_size(input logic [SIZE_W-1:0] value);
        wait_results();
        // trailing palette writes give no result but may still be in the chain
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_item();
        if ($urandom_range(0, 4) == 0)
            send_item(ACT_WRITE, INDEX_W'($urandom_range(0, ENTRIES - 1)),
                      rand_chan(), rand_chan(), rand_chan());
        else
            send_item(ACT_MAP, INDEX_W'($urandom_range(0, 255)),
                      rand_chan(), rand_chan(), rand_chan());
    endtask

    initial
    begin
        logic [SIZE_W-1:0] phase_size [8];

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small palette: black, white, pure red, duplicate white, near black
        set_search_size(9'd5);
        send_item(ACT_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);
        send_item(ACT_WRITE, 8'd1, 8'hff, 8'hff, 8'hff);
        send_item(ACT_WRITE, 8'd2, 8'hff, 8'h00, 8'h00);
        send_item(ACT_WRITE, 8'd3, 8'hff, 8'hff, 8'hff);
        send_item(ACT_WRITE, 8'd4, 8'h02, 8'h00, 8'h00);
        // top entry lies outside the searched range
        send_item(ACT_WRITE, 8'd255, 8'h12, 8'haa, 8'h55);
        send_item(ACT_MAP, 8'hff, 8'h00, 8'h00, 8'h00);
        // duplicate color: lower index wins
        send_item(ACT_MAP, 8'h00, 8'hff, 8'hff, 8'hff);
        send_item(ACT_MAP, 8'h5a, 8'hfe, 8'h01, 8'h00);
        // equidistant from entries 0 and 4
        send_item(ACT_MAP, 8'ha5, 8'h01, 8'h00, 8'h00);
        send_item(ACT_MAP, 8'h00, 8'h02, 8'h00, 8'h00);
        send_item(ACT_MAP, 8'h00, 8'h80, 8'h80, 8'h80);
        send_item(ACT_MAP, 8'h00, 8'h7f, 8'h7f, 8'h7f);
        send_item(ACT_MAP, 8'h00, 8'h80, 8'h00, 8'h00);
        // size zero searches entry 0 only
        set_search_size(9'd0);
        send_item(ACT_MAP, 8'h00, 8'hff, 8'hff, 8'hff);
        send_item(ACT_MAP, 8'h00, 8'h00, 8'hff, 8'h00);

        // every entry written before any full-size search
        set_search_size(SIZE_RESET);
        for (int e = 0; e < ENTRIES; e++)
            send_item(ACT_WRITE, INDEX_W'(e), rand_chan(), rand_chan(), rand_chan());

        phase_size[0] = SIZE_RESET;
        phase_size[1] = 9'd511;
        phase_size[2] = 9'd1;
        phase_size[3] = SIZE_W'($urandom_range(2, 255));
        phase_size[4] = 9'd0;
        phase_size[5] = SIZE_W'($urandom_range(257, 510));
        phase_size[6] = 9'd2;
        phase_size[7] = 9'd255;

        for (int p = 0; p < 8; p++)
        begin
            set_search_size(phase_size[p]);
            for (int n = 0; n < 115; n++)
            begin
                // hold off the sender once until the results catch up
                if (p == 3 && n == 75)
                    wait_results();
                send_random_item();
            end
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
src/npc_pkg.sv
src/npc_cell.sv
src/nearest_palette_color.sv
verif/npc_result_monitor.sv
verif/tb_nearest_palette_color.sv
